// File: rtl/core/qlsf_pkg.sv
// Shared constants, types and index helpers for the quadratic least-squares fit.
// Used by quadratic_least_squares_fit and its testbench; depends on nothing.
package qlsf_pkg;

	localparam int MAX_POINTS = 256;
	localparam int CNT_W      = 9;
	localparam int WIDE_W     = 256;   // exact determinant / quotient width
	localparam int ELEM_W     = 64;    // matrix element width
	localparam int SHIFT_A    = 24;
	localparam int SHIFT_B    = 20;
	localparam int SHIFT_C    = 16;

	typedef logic [WIDE_W-1:0] wide_t;
	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef enum logic [1:0] {
		FIT_OK       = 2'd0,
		FIT_FEW      = 2'd1,
		FIT_SINGULAR = 2'd2,
		FIT_TOO_MANY = 2'd3
	} fit_status_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_ACC  = 9'b000000010,
		S_POST = 9'b000000100,
		S_LOAD = 9'b000001000,
		S_MUL  = 9'b000010000,
		S_DET  = 9'b000100000,
		S_DIV  = 9'b001000000,
		S_QUO  = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	// determinant select: 0 system matrix, 1 a (col 2), 2 b (col 1), 3 c (col 0)
	function automatic logic [1:0] repl_col(input logic [1:0] det_sel);
		logic [1:0] r;
		case (det_sel)
			2'd1: r = 2'd2;
			2'd2: r = 2'd1;
			2'd3: r = 2'd0;
			default: r = 2'd3;
		endcase
		return r;
	endfunction

	// cofactor expansion along row 0: minor = e[a1]*e[b1] - e[a2]*e[b2]
	function automatic logic [3:0] idx_a1(input logic [1:0] term);
		logic [3:0] r;
		case (term)
			2'd0: r = 4'd4;
			default: r = 4'd3;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] idx_b1(input logic [1:0] term);
		logic [3:0] r;
		case (term)
			2'd2: r = 4'd7;
			default: r = 4'd8;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] idx_a2(input logic [1:0] term);
		logic [3:0] r;
		case (term)
			2'd2: r = 4'd4;
			default: r = 4'd5;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] idx_b2(input logic [1:0] term);
		logic [3:0] r;
		case (term)
			2'd0: r = 4'd7;
			default: r = 4'd6;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/quadratic_least_squares_fit.sv
// Quadratic least-squares fit: moment accumulation and exact Cramer's-rule solve.
// Depends on qlsf_pkg.
// A point that is not last is accumulated in S_ACC, then S_POST returns to S_IDLE.
// A last point adds the solve, unless there are fewer than three points or too many:
// four 3x3 determinants through one shift-add MAC (9 products each; a zero system
// determinant ends it early) and three restoring divisions; in_ready is low meanwhile.
// Reset clears the sums, count, flags and output valid; no clearing pass.
module quadratic_least_squares_fit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [11:0]         x_value,
	input  logic signed [15:0]  y_value,
	input  logic                last_point,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [47:0]  coef_square,
	output logic signed [47:0]  coef_linear,
	output logic signed [47:0]  coef_constant,
	output logic [1:0]          fit_status
);

	qlsf_pkg::state_t state_q;
	logic [2:0]  step_q;
	logic [qlsf_pkg::CNT_W-1:0] count_q;
	logic        too_many_q;
	logic [19:0] s1_q;
	logic [31:0] s2_q;
	logic [43:0] s3_q;
	logic [55:0] s4_q;
	logic signed [24:0] sy_q;
	logic signed [36:0] sxy_q;
	logic signed [48:0] sx2y_q;
	logic [1:0]  det_sel_q, term_q, part_q;
	logic [7:0]  cnt_q;
	logic        out_valid_q;

	logic [11:0] x_q;
	logic signed [15:0] y_q;
	logic        last_q;
	logic [23:0] x2_q;
	qlsf_pkg::wide_t mcand_q, minor_q, det_q, den_q, n_q, r_q;
	logic [qlsf_pkg::ELEM_W-1:0] mplier_q;
	logic        neg_q, tgt_det_q, dneg_q, qneg_q;
	logic signed [47:0] coef_a_q, coef_b_q, coef_c_q;
	logic signed [47:0] out_a_q, out_b_q, out_c_q;
	qlsf_pkg::fit_status_t status_q, out_status_q;

	// narrow multiplier for the per-point moments
	logic signed [24:0] mul_a, mul_b;
	logic signed [49:0] mul_p;

	always_comb begin
		mul_a = $signed({13'd0, x_q});
		mul_b = $signed({13'd0, x_q});
		case (step_q)
			3'd1: begin
				mul_a = $signed({1'b0, x2_q});
			end
			3'd2: begin
				mul_a = $signed({1'b0, x2_q});
				mul_b = $signed({1'b0, x2_q});
			end
			3'd3: begin
				mul_b = 25'(y_q);
			end
			3'd4: begin
				mul_a = $signed({1'b0, x2_q});
				mul_b = 25'(y_q);
			end
			default: ;
		endcase
		mul_p = mul_a * mul_b;
	end

	// matrix elements for the selected determinant
	qlsf_pkg::elem_t mm_e [9];
	qlsf_pkg::elem_t yv [3];
	qlsf_pkg::elem_t elem [9];
	logic [1:0] rcol;

	always_comb begin
		mm_e[0] = qlsf_pkg::ELEM_W'(count_q);
		mm_e[1] = qlsf_pkg::ELEM_W'(s1_q);
		mm_e[2] = qlsf_pkg::ELEM_W'(s2_q);
		mm_e[3] = qlsf_pkg::ELEM_W'(s1_q);
		mm_e[4] = qlsf_pkg::ELEM_W'(s2_q);
		mm_e[5] = qlsf_pkg::ELEM_W'(s3_q);
		mm_e[6] = qlsf_pkg::ELEM_W'(s2_q);
		mm_e[7] = qlsf_pkg::ELEM_W'(s3_q);
		mm_e[8] = qlsf_pkg::ELEM_W'(s4_q);
		yv[0] = qlsf_pkg::ELEM_W'(sy_q);
		yv[1] = qlsf_pkg::ELEM_W'(sxy_q);
		yv[2] = qlsf_pkg::ELEM_W'(sx2y_q);
		rcol = qlsf_pkg::repl_col(det_sel_q);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				elem[r*3+c] = (rcol == 2'(c)) ? yv[r] : mm_e[r*3+c];
			end
		end
	end

	// shared MAC adder: target +/- (mcand * current multiplier bit)
	qlsf_pkg::wide_t pp, addend, acc_in, acc_sum;
	logic mac_sub, mul_done;

	always_comb begin
		mul_done = (cnt_q[5:0] == 6'd63);
		pp       = mplier_q[0] ? mcand_q : '0;
		mac_sub  = neg_q ^ mul_done;   // top multiplier bit weighs negative
		addend   = mac_sub ? ~pp : pp;
		acc_in   = tgt_det_q ? det_q : minor_q;
		acc_sum  = acc_in + addend + qlsf_pkg::WIDE_W'(mac_sub);
	end

	// restoring division step
	qlsf_pkg::wide_t rn;
	logic [qlsf_pkg::WIDE_W:0] diff;
	logic ge;

	always_comb begin
		rn   = {r_q[qlsf_pkg::WIDE_W-2:0], n_q[qlsf_pkg::WIDE_W-1]};
		diff = {1'b0, rn} - {1'b0, den_q};
		ge   = !diff[qlsf_pkg::WIDE_W];
	end

	// numerator setup and quotient saturation
	qlsf_pkg::wide_t shifted;
	logic signed [47:0] sat_val;
	logic over;

	always_comb begin
		case (det_sel_q)
			2'd1: shifted = det_q << qlsf_pkg::SHIFT_A;
			2'd2: shifted = det_q << qlsf_pkg::SHIFT_B;
			default: shifted = det_q << qlsf_pkg::SHIFT_C;
		endcase
		over = |n_q[qlsf_pkg::WIDE_W-1:47];
		if (!qneg_q) begin
			sat_val = over ? 48'sh7FFF_FFFF_FFFF : $signed(n_q[47:0]);
		end else begin
			sat_val = over ? 48'sh8000_0000_0000 : -$signed(n_q[47:0]);
		end
	end

	logic in_xfer, fin_go;
	assign in_ready = (state_q == qlsf_pkg::S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign fin_go   = (state_q == qlsf_pkg::S_FIN) && (!out_valid_q || out_ready);

	// control and accumulated state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qlsf_pkg::S_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			too_many_q  <= 1'b0;
			s1_q        <= '0;
			s2_q        <= '0;
			s3_q        <= '0;
			s4_q        <= '0;
			sy_q        <= '0;
			sxy_q       <= '0;
			sx2y_q      <= '0;
			det_sel_q   <= '0;
			term_q      <= '0;
			part_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				qlsf_pkg::S_IDLE: begin
					if (in_valid) begin
						step_q <= '0;
						if (count_q == qlsf_pkg::CNT_W'(qlsf_pkg::MAX_POINTS)) begin
							too_many_q <= 1'b1;
							state_q    <= qlsf_pkg::S_POST;
						end else begin
							state_q <= qlsf_pkg::S_ACC;
						end
					end
				end
				qlsf_pkg::S_ACC: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						3'd0: begin
							count_q <= count_q + qlsf_pkg::CNT_W'(1);
							s1_q    <= s1_q + 20'(x_q);
							s2_q    <= s2_q + 32'(mul_p[23:0]);
							sy_q    <= sy_q + 25'(y_q);
						end
						3'd1: s3_q  <= s3_q + 44'(mul_p[35:0]);
						3'd2: s4_q  <= s4_q + 56'(mul_p[47:0]);
						3'd3: sxy_q <= sxy_q + 37'(mul_p);
						3'd4: begin
							sx2y_q  <= sx2y_q + 49'(mul_p);
							state_q <= qlsf_pkg::S_POST;
						end
						default: ;
					endcase
				end
				qlsf_pkg::S_POST: begin
					if (!last_q) begin
						state_q <= qlsf_pkg::S_IDLE;
					end else if (too_many_q || count_q < qlsf_pkg::CNT_W'(3)) begin
						state_q <= qlsf_pkg::S_FIN;
					end else begin
						det_sel_q <= '0;
						term_q    <= '0;
						part_q    <= '0;
						state_q   <= qlsf_pkg::S_LOAD;
					end
				end
				qlsf_pkg::S_LOAD: begin
					cnt_q   <= '0;
					state_q <= qlsf_pkg::S_MUL;
				end
				qlsf_pkg::S_MUL: begin
					cnt_q <= cnt_q + 8'd1;
					if (mul_done) begin
						if (part_q != 2'd2) begin
							part_q  <= part_q + 2'd1;
							state_q <= qlsf_pkg::S_LOAD;
						end else if (term_q != 2'd2) begin
							part_q  <= '0;
							term_q  <= term_q + 2'd1;
							state_q <= qlsf_pkg::S_LOAD;
						end else begin
							state_q <= qlsf_pkg::S_DET;
						end
					end
				end
				qlsf_pkg::S_DET: begin
					term_q <= '0;
					part_q <= '0;
					cnt_q  <= '0;
					if (det_sel_q == 2'd0) begin
						if (det_q == '0) begin
							state_q <= qlsf_pkg::S_FIN;
						end else begin
							det_sel_q <= 2'd1;
							state_q   <= qlsf_pkg::S_LOAD;
						end
					end else begin
						state_q <= qlsf_pkg::S_DIV;
					end
				end
				qlsf_pkg::S_DIV: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'hFF) begin
						state_q <= qlsf_pkg::S_QUO;
					end
				end
				qlsf_pkg::S_QUO: begin
					if (det_sel_q == 2'd3) begin
						state_q <= qlsf_pkg::S_FIN;
					end else begin
						det_sel_q <= det_sel_q + 2'd1;
						term_q    <= '0;
						part_q    <= '0;
						state_q   <= qlsf_pkg::S_LOAD;
					end
				end
				qlsf_pkg::S_FIN: begin
					if (fin_go) begin
						count_q     <= '0;
						too_many_q  <= 1'b0;
						s1_q        <= '0;
						s2_q        <= '0;
						s3_q        <= '0;
						s4_q        <= '0;
						sy_q        <= '0;
						sxy_q       <= '0;
						sx2y_q      <= '0;
						state_q     <= qlsf_pkg::S_IDLE;
					end
				end
				default: state_q <= qlsf_pkg::S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			qlsf_pkg::S_IDLE: begin
				if (in_xfer) begin
					x_q    <= x_value;
					y_q    <= y_value;
					last_q <= last_point;
				end
			end
			qlsf_pkg::S_ACC: begin
				if (step_q == 3'd0) begin
					x2_q <= mul_p[23:0];
				end
			end
			qlsf_pkg::S_POST: begin
				coef_a_q <= '0;
				coef_b_q <= '0;
				coef_c_q <= '0;
				det_q    <= '0;
				if (too_many_q) begin
					status_q <= qlsf_pkg::FIT_TOO_MANY;
				end else if (count_q < qlsf_pkg::CNT_W'(3)) begin
					status_q <= qlsf_pkg::FIT_FEW;
				end else begin
					status_q <= qlsf_pkg::FIT_OK;
				end
			end
			qlsf_pkg::S_LOAD: begin
				case (part_q)
					2'd0: begin
						minor_q   <= '0;
						mcand_q   <= qlsf_pkg::WIDE_W'(elem[qlsf_pkg::idx_a1(term_q)]);
						mplier_q  <= elem[qlsf_pkg::idx_b1(term_q)];
						neg_q     <= 1'b0;
						tgt_det_q <= 1'b0;
					end
					2'd1: begin
						mcand_q   <= qlsf_pkg::WIDE_W'(elem[qlsf_pkg::idx_a2(term_q)]);
						mplier_q  <= elem[qlsf_pkg::idx_b2(term_q)];
						neg_q     <= 1'b1;
						tgt_det_q <= 1'b0;
					end
					default: begin
						mcand_q   <= minor_q;
						mplier_q  <= elem[{2'b00, term_q}];
						neg_q     <= (term_q == 2'd1);
						tgt_det_q <= 1'b1;
					end
				endcase
			end
			qlsf_pkg::S_MUL: begin
				if (tgt_det_q) begin
					det_q <= acc_sum;
				end else begin
					minor_q <= acc_sum;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			qlsf_pkg::S_DET: begin
				if (det_sel_q == 2'd0) begin
					if (det_q == '0) begin
						status_q <= qlsf_pkg::FIT_SINGULAR;
					end else begin
						dneg_q <= det_q[qlsf_pkg::WIDE_W-1];
						den_q  <= det_q[qlsf_pkg::WIDE_W-1] ? -det_q : det_q;
						det_q  <= '0;
					end
				end else begin
					qneg_q <= det_q[qlsf_pkg::WIDE_W-1] ^ dneg_q;
					n_q    <= shifted[qlsf_pkg::WIDE_W-1] ? -shifted : shifted;
					r_q    <= '0;
				end
			end
			qlsf_pkg::S_DIV: begin
				r_q <= ge ? diff[qlsf_pkg::WIDE_W-1:0] : rn;
				n_q <= {n_q[qlsf_pkg::WIDE_W-2:0], ge};
			end
			qlsf_pkg::S_QUO: begin
				det_q <= '0;
				case (det_sel_q)
					2'd1: coef_a_q <= sat_val;
					2'd2: coef_b_q <= sat_val;
					default: coef_c_q <= sat_val;
				endcase
			end
			qlsf_pkg::S_FIN: begin
				if (fin_go) begin
					out_a_q      <= coef_a_q;
					out_b_q      <= coef_b_q;
					out_c_q      <= coef_c_q;
					out_status_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign coef_square   = out_a_q;
	assign coef_linear   = out_b_q;
	assign coef_constant = out_c_q;
	assign fit_status    = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qlsf_pkg::CNT_W'(qlsf_pkg::MAX_POINTS))
		else $error("point count beyond limit");

	a_flag_full: assert property (@(posedge clk) disable iff (!arst_n)
		too_many_q |-> count_q == qlsf_pkg::CNT_W'(qlsf_pkg::MAX_POINTS))
		else $error("overflow flag without full count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != qlsf_pkg::FIT_OK |->
			out_a_q == '0 && out_b_q == '0 && out_c_q == '0)
		else $error("nonzero coefficients on failed fit");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> count_q == '0 && !too_many_q && s4_q == '0)
		else $error("sums not cleared after result");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == qlsf_pkg::S_MUL || state_q == qlsf_pkg::S_DIV) |-> !in_ready)
		else $error("input ready during solve");

endmodule

// File: test/quadratic_least_squares_fit_test.sv
// Self-checking testbench for quadratic_least_squares_fit: streams point sets and
// checks each fit against an exact wide-integer Cramer's-rule solve. Depends on qlsf_pkg.
`timescale 1ns / 1ps

module quadratic_least_squares_fit_test;

	typedef logic signed [255:0] big_t;

	typedef struct {
		logic [11:0]        x;
		logic signed [15:0] y;
		logic               last;
	} point_t;

	typedef struct {
		logic signed [47:0]    a;
		logic signed [47:0]    b;
		logic signed [47:0]    c;
		qlsf_pkg::fit_status_t status;
	} fit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [11:0]        x_value = '0;
	logic signed [15:0] y_value = '0;
	logic               last_point = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [47:0] coef_square, coef_linear, coef_constant;
	logic [1:0]         fit_status;

	point_t pending_points[$];
	fit_t   expected_fits[$];
	int     errors = 0;
	int     fits_seen = 0;
	int     cycle = 0;
	int     points_sent = 0;
	bit     point_taken = 1'b0;

	// running moments of the open point set
	int      n_pts;
	bit      overflowed;
	longint  s1, s2, s3, s4, sy, sxy, sx2y;

	quadratic_least_squares_fit uut (.*);

	always #5 clk = ~clk;

	task automatic clear_moments();
		n_pts = 0; overflowed = 0;
		s1 = 0; s2 = 0; s3 = 0; s4 = 0; sy = 0; sxy = 0; sx2y = 0;
	endtask

	function automatic big_t det3(input longint m[9]);
		big_t e[9];
		for (int i = 0; i < 9; i++) e[i] = m[i];
		return e[0] * (e[4] * e[8] - e[5] * e[7]) - e[1] * (e[3] * e[8] - e[5] * e[6])
			+ e[2] * (e[3] * e[7] - e[4] * e[6]);
	endfunction

	// (num * 2^sh) / den toward zero, saturated to 48-bit signed
	function automatic logic signed [47:0] q24_quotient(input big_t num, input big_t den,
			input int sh);
		big_t n, d, q, lim;
		bit neg;
		neg = (num < 0) != (den < 0);
		n = num <<< sh;
		if (n < 0) n = -n;
		d = (den < 0) ? -den : den;
		q = n / d;
		lim = 1;
		lim = lim <<< 47;
		if (q >= lim) return neg ? 48'sh800000000000 : 48'sh7FFFFFFFFFFF;
		return neg ? -q[47:0] : q[47:0];
	endfunction

	task automatic add_point(input point_t p);
		longint x, y, x2;
		fit_t f;
		big_t dm;
		longint mm[9], ma[9], mb[9], mc[9];
		x = p.x;
		y = p.y;
		x2 = x * x;
		if (n_pts >= qlsf_pkg::MAX_POINTS) overflowed = 1;
		else begin
			n_pts++;
			s1 += x; s2 += x2; s3 += x2 * x; s4 += x2 * x2;
			sy += y; sxy += x * y; sx2y += x2 * y;
		end
		if (!p.last) return;
		f.a = 0; f.b = 0; f.c = 0;
		if (overflowed) f.status = qlsf_pkg::FIT_TOO_MANY;
		else if (n_pts < 3) f.status = qlsf_pkg::FIT_FEW;
		else begin
			mm = '{n_pts, s1, s2, s1, s2, s3, s2, s3, s4};
			ma = '{n_pts, s1, sy, s1, s2, sxy, s2, s3, sx2y};
			mb = '{n_pts, sy, s2, s1, sxy, s3, s2, sx2y, s4};
			mc = '{sy, s1, s2, sxy, s2, s3, sx2y, s3, s4};
			dm = det3(mm);
			if (dm == 0) f.status = qlsf_pkg::FIT_SINGULAR;
			else begin
				f.status = qlsf_pkg::FIT_OK;
				f.a = q24_quotient(det3(ma), dm, qlsf_pkg::SHIFT_A);
				f.b = q24_quotient(det3(mb), dm, qlsf_pkg::SHIFT_B);
				f.c = q24_quotient(det3(mc), dm, qlsf_pkg::SHIFT_C);
			end
		end
		expected_fits = {expected_fits, f};
		clear_moments();
	endtask

	// no idling on either side for a stretch in the middle of the run
	function automatic bit idle_now();
		if (cycle > 30000 && cycle < 60000) return 0;
		return $urandom_range(99) < 38;
	endfunction

	// transfers are taken at the rising edge
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (arst_n && in_valid && in_ready) begin
			add_point('{x_value, y_value, last_point});
			point_taken = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			fit_t f;
			fits_seen++;
			if (expected_fits.size() == 0) begin
				$error("fit result with nothing expected");
				errors++;
			end else begin
				f = expected_fits.pop_front();
				if (coef_square !== f.a) begin
					$error("coef_square expected %0d got %0d", f.a, coef_square);
					errors++;
				end
				if (coef_linear !== f.b) begin
					$error("coef_linear expected %0d got %0d", f.b, coef_linear);
					errors++;
				end
				if (coef_constant !== f.c) begin
					$error("coef_constant expected %0d got %0d", f.c, coef_constant);
					errors++;
				end
				if (fit_status !== f.status) begin
					$error("fit_status expected %0d got %0d", f.status, fit_status);
					errors++;
				end
			end
		end
	end

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		point_t p;
		if (arst_n) begin
			if (!in_valid || point_taken) begin
				if (pending_points.size() != 0 && !idle_now()) begin
					p = pending_points.pop_front();
					x_value <= p.x;
					y_value <= p.y;
					last_point <= p.last;
					in_valid <= 1'b1;
					points_sent++;
				end else
					in_valid <= 1'b0;
			end
			out_ready <= !idle_now();
		end
		point_taken = 1'b0;
	end

	task automatic queue_point(input int x, input int y, input bit last);
		point_t p;
		p.x = 12'(x);
		p.y = 16'(y);
		p.last = last;
		pending_points = {pending_points, p};
	endtask

	// one set of points; mode picks how x is spread
	task automatic queue_set(input int count, input int mode);
		int xs[3];
		int x;
		for (int k = 0; k < 3; k++) xs[k] = $urandom_range(4095);
		for (int i = 0; i < count; i++) begin
			case (mode)
				0: x = $urandom_range(4095);
				1: x = xs[$urandom_range(2)];
				2: x = xs[$urandom_range(1)];      // at most two distinct x
				default: x = $urandom_range(15);
			endcase
			queue_point(x, $urandom_range(65535), i == count - 1);
		end
	endtask

	initial begin
		int queued, sets, size;
		clear_moments();
		// directed: lone point, two points, singular, extremes
		queue_point(4095, -32768, 1);
		queue_point(0, 32767, 0);
		queue_point(4095, -32768, 1);
		queue_point(7, 100, 0);
		queue_point(7, -100, 0);
		queue_point(7, 5, 1);
		queue_point(0, 32767, 0);
		queue_point(1, -32768, 0);
		queue_point(2, 32767, 1);
		queue_point(0, -32768, 0);
		queue_point(2048, 32767, 0);
		queue_point(4095, -32768, 0);
		queue_point(4095, 0, 1);
		queue_point(0, 0, 0);
		queue_point(4094, 1, 0);
		queue_point(4095, -1, 1);
		// one set that runs past the point limit
		queue_set(qlsf_pkg::MAX_POINTS + 2, 0);
		queued = 16 + qlsf_pkg::MAX_POINTS + 2;
		sets = 7;
		// random sets: mostly short, now and then one near the point limit
		while (queued < 600) begin
			if ($urandom_range(19) == 0 && queued + qlsf_pkg::MAX_POINTS + 4 <= 600)
				size = $urandom_range(qlsf_pkg::MAX_POINTS - 2, qlsf_pkg::MAX_POINTS + 4);
			else size = $urandom_range(1, 12);
			queue_set(size, $urandom_range(5) < 3 ? 0 : $urandom_range(1, 3));
			queued += size;
			sets++;
		end
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		wait (pending_points.size() == 0 && !in_valid && expected_fits.size() == 0);
		repeat (20) @(posedge clk);
		$display("%0d points in %0d sets sent, %0d fits checked", points_sent, sets,
			fits_seen);
		if (errors == 0 && expected_fits.size() == 0)
			$display("quadratic_least_squares_fit_test passed");
		else
			$display("quadratic_least_squares_fit_test failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("quadratic_least_squares_fit_test failed");
		$finish;
	end

endmodule

// File: quadratic_least_squares_fit.f
rtl/core/qlsf_pkg.sv
rtl/core/quadratic_least_squares_fit.sv
test/quadratic_least_squares_fit_test.sv
